// ----- hw/rtl/lzss_length_coded_decoder_defines.svh -----
// assertion macros used by the decoder controller
// expects clk_i and rst_ni in the scope of each use
`ifndef LZSS_LENGTH_CODED_DECODER_DEFINES_SVH
`define LZSS_LENGTH_CODED_DECODER_DEFINES_SVH

// property must hold at every clock out of reset
`define LZSSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition must never be seen
`define LZSSD_ASSERT_NEVER(lbl, cond, msg) \
  `LZSSD_ASSERT(lbl, !(cond), msg)

`endif

// ----- hw/rtl/lzssd_pkg.sv -----
// shared types and constants of the length-coded lzss decoder
// no dependencies
`default_nettype none

package lzssd_pkg;

  localparam int OFFSET_WIDTH = 10;
  localparam int WIN_DEPTH    = 1 << OFFSET_WIDTH;
  localparam int OUT_LANES    = 8;
  localparam int CNT_W        = 4;
  localparam int LEN_W        = 9;
  localparam int ACC_W        = 12;
  localparam int FBL_W        = 4;
  localparam int MAX_COPY     = 271;
  localparam int STAGE_DEPTH  = 272;
  localparam int STAGE_AW     = $clog2(STAGE_DEPTH);

  localparam logic [7:0] FILL_BYTE   = 8'h20;
  localparam logic [7:0] END_CODE    = 8'hFF;
  localparam logic [2:0] LONG_PREFIX = 3'd4;
  localparam logic [3:0] LIT_BITS    = 4'd8;
  localparam logic [3:0] LONG_BITS   = 4'd8;

  // register index carried in paddr[2]
  localparam logic REG_LITERAL_FLAG = 1'b0;

  typedef enum logic [2:0] {
    PH_FLAG    = 3'd0,
    PH_LITERAL = 3'd1,
    PH_PREFIX  = 3'd2,
    PH_LENGTH  = 3'd3,
    PH_OFFSET  = 3'd4
  } parse_phase_e;

  typedef enum logic [9:0] {
    S_IDLE      = 10'b0000000001,
    S_BITS      = 10'b0000000010,
    S_CP_RD     = 10'b0000000100,
    S_CP_WR     = 10'b0000001000,
    S_WR_RD     = 10'b0000010000,
    S_WR_EM     = 10'b0000100000,
    S_FLUSH     = 10'b0001000000,
    S_END_FLUSH = 10'b0010000000,
    S_END_RES   = 10'b0100000000,
    S_DONE      = 10'b1000000000
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic step;
    logic cp_rd;
    logic cp_wr;
    logic wr_rd;
    logic wr_em;
    logic push_buf;
    logic push_last;
    logic push_end;
  } dp_cmd_t;

  typedef struct packed {
    logic lit_done;
    logic copy_go;
    logic end_go;
    logic last_bit;
    logic bits_empty;
    logic k_last;
    logic emit_ok;
    logic buf_empty;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/lzss_length_coded_decoder.sv -----
// sequence: an input byte is loaded, its eight bits are parsed, then packed bytes are flushed;
// a copy reads its bytes from the window into staging, then writes each back and packs it
// one input byte at a time, held longer under output stall; results leave an output register
// reset: async active low; window reads as spaces until written, no clearing pass needed
// depends on lzssd_pkg, lzssd_ctrl, lzssd_dp
`default_nettype none

module lzss_length_coded_decoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  compressed_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [63:0]      out_bytes_o,
  output logic [3:0]       byte_count_o,
  output logic             last_of_run_o,
  output logic             end_seen_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic               lit_flag_q;
  lzssd_pkg::dp_cmd_t cmd;
  lzssd_pkg::dp_sts_t sts;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == lzssd_pkg::REG_LITERAL_FLAG) ? {31'd0, lit_flag_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lit_flag_q <= 1'b0;
    end else if (psel && penable && pwrite && paddr[2] == lzssd_pkg::REG_LITERAL_FLAG) begin
      lit_flag_q <= pwdata[0];
    end
  end

  lzssd_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  lzssd_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_i       (compressed_byte_i),
    .lit_flag_i   (lit_flag_q),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_bytes_o  (out_bytes_o),
    .byte_count_o (byte_count_o),
    .last_of_run_o(last_of_run_o),
    .end_seen_o   (end_seen_o)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/lzssd_ram.sv -----
// generic one-write one-read ram with registered read data
// no dependencies
`default_nettype none

module lzssd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/lzssd_dp.sv -----
// datapath: bit parser, window and staging rams, output packer
// depends on lzssd_pkg and lzssd_ram
`default_nettype none

module lzssd_dp (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [7:0]        byte_i,
  input  wire logic              lit_flag_i,
  input  wire lzssd_pkg::dp_cmd_t cmd_i,
  output lzssd_pkg::dp_sts_t     sts_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [63:0]            out_bytes_o,
  output logic [3:0]             byte_count_o,
  output logic                   last_of_run_o,
  output logic                   end_seen_o
);

  localparam int OW = lzssd_pkg::OFFSET_WIDTH;
  localparam int LW = lzssd_pkg::LEN_W;
  localparam int CW = lzssd_pkg::CNT_W;

  logic [7:0]                  byte_q, byte_d;
  logic [3:0]                  bits_q, bits_d;
  lzssd_pkg::parse_phase_e     phase_q, phase_d;
  logic [2:0]                  prefix_q, prefix_d;
  logic [lzssd_pkg::FBL_W-1:0] fbl_q, fbl_d;
  logic [lzssd_pkg::ACC_W-1:0] acc_q, acc_d;
  logic [LW-1:0]               len_q, len_d;
  logic [OW-1:0]               off_q, off_d;
  logic [OW-1:0]               wp_q, wp_d;
  logic                        wrapped_q, wrapped_d;
  logic [LW-1:0]               k_q, k_d;
  logic                        rv_q, rv_d;
  logic [63:0]                 buf_q, buf_d;
  logic [CW-1:0]               cnt_q, cnt_d;
  logic                        ov_q, ov_d;
  logic [63:0]                 ob_q, ob_d;
  logic [CW-1:0]               oc_q, oc_d;
  logic                        ol_q, ol_d;
  logic                        oe_q, oe_d;

  logic                        bit_v;
  logic [lzssd_pkg::ACC_W-1:0] acc_sh;
  logic [lzssd_pkg::FBL_W-1:0] fbl_dec;
  logic                        field_done;
  logic [9:0]                  len_raw;
  logic [LW-1:0]               len_sat;
  logic                        lit_done, copy_go, end_go;
  logic                        k_last, out_free, emit_ok, emit;
  logic                        win_we;
  logic [7:0]                  win_wdata, win_rdata, stg_wdata, stg_rdata;
  logic [OW-1:0]               win_raddr;

  // ---------------- bit parser
  always_comb begin
    bit_v      = byte_q[7];
    acc_sh     = {acc_q[lzssd_pkg::ACC_W-2:0], bit_v};
    fbl_dec    = (fbl_q != '0) ? fbl_q - 1'b1 : '0;
    field_done = (fbl_dec == '0);
    len_raw    = (10'd2 << prefix_q) + {2'b00, acc_sh[7:0]};
    len_sat    = (len_raw > 10'(lzssd_pkg::MAX_COPY)) ? LW'(lzssd_pkg::MAX_COPY)
                                                      : len_raw[LW-1:0];
    phase_d  = phase_q;
    prefix_d = prefix_q;
    fbl_d    = fbl_q;
    acc_d    = acc_q;
    len_d    = len_q;
    off_d    = off_q;
    lit_done = 1'b0;
    copy_go  = 1'b0;
    end_go   = 1'b0;
    case (phase_q)
      lzssd_pkg::PH_FLAG: begin
        if (bit_v == lit_flag_i) begin
          phase_d = lzssd_pkg::PH_LITERAL;
          fbl_d   = lzssd_pkg::LIT_BITS;
          acc_d   = '0;
        end else begin
          phase_d  = lzssd_pkg::PH_PREFIX;
          prefix_d = '0;
        end
      end
      lzssd_pkg::PH_LITERAL: begin
        acc_d = acc_sh;
        fbl_d = fbl_dec;
        if (field_done) begin
          lit_done = 1'b1;
          phase_d  = lzssd_pkg::PH_FLAG;
        end
      end
      lzssd_pkg::PH_PREFIX: begin
        if (bit_v) begin
          if (prefix_q >= lzssd_pkg::LONG_PREFIX - 3'd1) begin
            prefix_d = lzssd_pkg::LONG_PREFIX;
            phase_d  = lzssd_pkg::PH_LENGTH;
            fbl_d    = lzssd_pkg::LONG_BITS;
            acc_d    = '0;
          end else begin
            prefix_d = prefix_q + 3'd1;
          end
        end else begin
          phase_d = lzssd_pkg::PH_LENGTH;
          fbl_d   = {1'b0, prefix_q} + 4'd1;
          acc_d   = '0;
        end
      end
      lzssd_pkg::PH_LENGTH: begin
        acc_d = acc_sh;
        fbl_d = fbl_dec;
        if (field_done) begin
          if (prefix_q == lzssd_pkg::LONG_PREFIX &&
              acc_sh == {4'h0, lzssd_pkg::END_CODE}) begin
            end_go = 1'b1;
          end else begin
            len_d   = len_sat;
            phase_d = lzssd_pkg::PH_OFFSET;
            fbl_d   = lzssd_pkg::FBL_W'(OW);
            acc_d   = '0;
          end
        end
      end
      lzssd_pkg::PH_OFFSET: begin
        acc_d = acc_sh;
        fbl_d = fbl_dec;
        if (field_done) begin
          copy_go = 1'b1;
          off_d   = acc_sh[OW-1:0];
          phase_d = lzssd_pkg::PH_FLAG;
        end
      end
      default: begin
        phase_d = lzssd_pkg::PH_FLAG;
      end
    endcase
  end

  // ---------------- window and staging
  assign k_last    = (k_q == len_q - 1'b1);
  assign win_we    = (cmd_i.step && lit_done) || cmd_i.wr_em;
  assign win_wdata = cmd_i.wr_em ? stg_rdata : acc_sh[7:0];
  assign win_raddr = off_q + OW'(k_q);
  // an entry never written yet reads as a space
  assign stg_wdata = rv_q ? win_rdata : lzssd_pkg::FILL_BYTE;
  assign emit      = win_we;

  lzssd_ram #(
    .WIDTH(8),
    .DEPTH(lzssd_pkg::WIN_DEPTH)
  ) u_win_ram (
    .clk_i  (clk_i),
    .we_i   (win_we),
    .waddr_i(wp_q),
    .wdata_i(win_wdata),
    .re_i   (cmd_i.cp_rd),
    .raddr_i(win_raddr),
    .rdata_o(win_rdata)
  );

  lzssd_ram #(
    .WIDTH(8),
    .DEPTH(lzssd_pkg::STAGE_DEPTH)
  ) u_stg_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.cp_wr),
    .waddr_i(k_q),
    .wdata_i(stg_wdata),
    .re_i   (cmd_i.wr_rd),
    .raddr_i(k_q),
    .rdata_o(stg_rdata)
  );

  // ---------------- packer and output register
  assign out_free = !ov_q || !out_stall_i;
  assign emit_ok  = (cnt_q < CW'(lzssd_pkg::OUT_LANES)) || out_free;

  always_comb begin
    byte_d    = byte_q;
    bits_d    = bits_q;
    wp_d      = wp_q;
    wrapped_d = wrapped_q;
    k_d       = k_q;
    rv_d      = rv_q;
    buf_d     = buf_q;
    cnt_d     = cnt_q;
    ob_d      = ob_q;
    oc_d      = oc_q;
    ol_d      = ol_q;
    oe_d      = oe_q;
    ov_d      = ov_q && out_stall_i;

    if (cmd_i.load) begin
      byte_d = byte_i;
      bits_d = 4'd8;
    end
    if (cmd_i.step) begin
      byte_d = {byte_q[6:0], 1'b0};
      bits_d = bits_q - 4'd1;
    end
    if (cmd_i.cp_rd) begin
      rv_d = wrapped_q || (win_raddr < wp_q);
    end
    if (cmd_i.cp_wr || cmd_i.wr_em) begin
      k_d = k_last ? '0 : k_q + 1'b1;
    end
    if (win_we) begin
      wp_d = wp_q + 1'b1;
      if (wp_q == '1) begin
        wrapped_d = 1'b1;
      end
    end

    if (emit) begin
      if (cnt_q == CW'(lzssd_pkg::OUT_LANES)) begin
        ov_d  = 1'b1;
        ob_d  = buf_q;
        oc_d  = cnt_q;
        ol_d  = 1'b0;
        oe_d  = 1'b0;
        buf_d = {56'd0, win_wdata};
        cnt_d = CW'(1);
      end else begin
        for (int l = 0; l < lzssd_pkg::OUT_LANES; l++) begin
          if (cnt_q == CW'(l)) begin
            buf_d[8*l +: 8] = win_wdata;
          end
        end
        cnt_d = cnt_q + 1'b1;
      end
    end
    if (cmd_i.push_buf) begin
      ov_d  = 1'b1;
      ob_d  = buf_q;
      oc_d  = cnt_q;
      ol_d  = cmd_i.push_last;
      oe_d  = 1'b0;
      buf_d = '0;
      cnt_d = '0;
    end
    if (cmd_i.push_end) begin
      ov_d = 1'b1;
      ob_d = '0;
      oc_d = '0;
      ol_d = 1'b1;
      oe_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_q    <= '0;
      phase_q   <= lzssd_pkg::PH_FLAG;
      prefix_q  <= '0;
      fbl_q     <= '0;
      acc_q     <= '0;
      len_q     <= '0;
      wp_q      <= '0;
      wrapped_q <= 1'b0;
      k_q       <= '0;
      buf_q     <= '0;
      cnt_q     <= '0;
      ov_q      <= 1'b0;
    end else begin
      bits_q    <= bits_d;
      wp_q      <= wp_d;
      wrapped_q <= wrapped_d;
      k_q       <= k_d;
      buf_q     <= buf_d;
      cnt_q     <= cnt_d;
      ov_q      <= ov_d;
      if (cmd_i.step) begin
        phase_q  <= phase_d;
        prefix_q <= prefix_d;
        fbl_q    <= fbl_d;
        acc_q    <= acc_d;
        len_q    <= len_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    rv_q   <= rv_d;
    ob_q   <= ob_d;
    oc_q   <= oc_d;
    ol_q   <= ol_d;
    oe_q   <= oe_d;
    if (cmd_i.step) begin
      off_q <= off_d;
    end
  end

  always_comb begin
    sts_o.lit_done   = lit_done;
    sts_o.copy_go    = copy_go;
    sts_o.end_go     = end_go;
    sts_o.last_bit   = (bits_q == 4'd1);
    sts_o.bits_empty = (bits_q == 4'd0);
    sts_o.k_last     = k_last;
    sts_o.emit_ok    = emit_ok;
    sts_o.buf_empty  = (cnt_q == '0);
    sts_o.out_free   = out_free;
  end

  assign out_valid_o   = ov_q;
  assign out_bytes_o   = ob_q;
  assign byte_count_o  = oc_q;
  assign last_of_run_o = ol_q;
  assign end_seen_o    = oe_q;

endmodule

`default_nettype wire

// ----- hw/rtl/lzssd_ctrl.sv -----
// controller: sequences bit parsing, copy walks and result flushes
// depends on lzssd_pkg and the assertion macro header
`default_nettype none

`include "lzss_length_coded_decoder_defines.svh"

module lzssd_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire lzssd_pkg::dp_sts_t sts_i,
  output lzssd_pkg::dp_cmd_t      cmd_o
);

  lzssd_pkg::ctrl_state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      lzssd_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = lzssd_pkg::S_BITS;
        end
      end
      lzssd_pkg::S_BITS: begin
        if (sts_i.end_go) begin
          state_d = lzssd_pkg::S_END_FLUSH;
        end else if (!sts_i.lit_done || sts_i.emit_ok) begin
          cmd_o.step = 1'b1;
          if (sts_i.copy_go) begin
            state_d = lzssd_pkg::S_CP_RD;
          end else if (sts_i.last_bit) begin
            state_d = lzssd_pkg::S_FLUSH;
          end
        end
      end
      lzssd_pkg::S_CP_RD: begin
        cmd_o.cp_rd = 1'b1;
        state_d     = lzssd_pkg::S_CP_WR;
      end
      lzssd_pkg::S_CP_WR: begin
        cmd_o.cp_wr = 1'b1;
        state_d     = sts_i.k_last ? lzssd_pkg::S_WR_RD : lzssd_pkg::S_CP_RD;
      end
      lzssd_pkg::S_WR_RD: begin
        cmd_o.wr_rd = 1'b1;
        state_d     = lzssd_pkg::S_WR_EM;
      end
      lzssd_pkg::S_WR_EM: begin
        if (sts_i.emit_ok) begin
          cmd_o.wr_em = 1'b1;
          if (!sts_i.k_last) begin
            state_d = lzssd_pkg::S_WR_RD;
          end else if (sts_i.bits_empty) begin
            state_d = lzssd_pkg::S_FLUSH;
          end else begin
            state_d = lzssd_pkg::S_BITS;
          end
        end
      end
      lzssd_pkg::S_FLUSH: begin
        if (sts_i.buf_empty) begin
          state_d = lzssd_pkg::S_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.push_buf  = 1'b1;
          cmd_o.push_last = 1'b1;
          state_d         = lzssd_pkg::S_IDLE;
        end
      end
      lzssd_pkg::S_END_FLUSH: begin
        if (sts_i.buf_empty) begin
          state_d = lzssd_pkg::S_END_RES;
        end else if (sts_i.out_free) begin
          cmd_o.push_buf = 1'b1;
          state_d        = lzssd_pkg::S_END_RES;
        end
      end
      lzssd_pkg::S_END_RES: begin
        if (sts_i.out_free) begin
          cmd_o.push_end = 1'b1;
          state_d        = lzssd_pkg::S_DONE;
        end
      end
      lzssd_pkg::S_DONE: begin
        // input after the end marker is swallowed
        in_stall_o = 1'b0;
      end
      default: begin
        state_d = lzssd_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lzssd_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `LZSSD_ASSERT(a_done_sticky, (state_q == lzssd_pkg::S_DONE) |=> (state_q == lzssd_pkg::S_DONE), "left done state")
  `LZSSD_ASSERT_NEVER(a_lit_overflow, cmd_o.step && sts_i.lit_done && !sts_i.emit_ok, "literal lost in packer")
  `LZSSD_ASSERT_NEVER(a_end_with_data, cmd_o.push_end && !sts_i.buf_empty, "end result before data drained")
  `LZSSD_ASSERT_NEVER(a_push_busy, cmd_o.push_buf && !sts_i.out_free, "push into busy output register")

endmodule

`default_nettype wire

// ----- sim/lzss_length_coded_decoder_test.sv -----
// testbench for the length-coded lzss decoder: random and directed compressed streams,
// predicted results checked word by word; depends on lzssd_pkg and lzss_length_coded_decoder
`default_nettype none

module lzss_length_coded_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int OW = lzssd_pkg::OFFSET_WIDTH;
  localparam int WD = lzssd_pkg::WIN_DEPTH;

  typedef struct packed {
    logic [63:0] bytes;
    logic [3:0]  count;
    logic        last;
    logic        ended;
  } dec_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic [7:0] compressed_byte_i = '0;
  logic out_stall_i = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic in_stall_o, out_valid_o, last_of_run_o, end_seen_o, pready;
  logic [63:0] out_bytes_o;
  logic [3:0] byte_count_o;
  logic [31:0] prdata;

  lzss_length_coded_decoder u_top (.*);

  initial forever #6 clk_i = ~clk_i;

  // predictor state
  logic [7:0] win [WD];
  logic [OW-1:0] wptr;
  lzssd_pkg::parse_phase_e phase;
  int unsigned ones, bits_left, acc, copy_len;
  bit ended, lit_flag;

  dec_word_t expected_words[$];
  logic [7:0] pending_bytes[$];
  int errors = 0;
  int send_idle = 33, recv_idle = 66;
  int hold_cycles = 0;
  longint cycles = 0;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    errors++;
    $display("mismatch %s: got %h want %h", what, got, want);
  endtask

  function automatic void decoder_reset();
    for (int i = 0; i < WD; i++) win[i] = lzssd_pkg::FILL_BYTE;
    wptr = '0; phase = lzssd_pkg::PH_FLAG; ones = 0; bits_left = 0; acc = 0; copy_len = 0;
    ended = 0; lit_flag = 0;
  endfunction

  function automatic bit shift_in(input int unsigned b);
    acc = ((acc << 1) | b) & 12'hFFF;
    if (bits_left > 0) bits_left--;
    return bits_left == 0;
  endfunction

  function automatic void decode_byte(input logic [7:0] cb);
    logic [7:0] em[$];
    logic [7:0] stage[$];
    bit hit;
    int unsigned b, n, ln;
    logic [OW-1:0] off;
    dec_word_t w;
    hit = 0;
    if (ended) return;
    for (int i = 7; i >= 0 && !hit; i--) begin
      b = cb[i];
      case (phase)
        lzssd_pkg::PH_FLAG: begin
          if (b == lit_flag) begin
            phase = lzssd_pkg::PH_LITERAL; bits_left = 8; acc = 0;
          end else begin
            phase = lzssd_pkg::PH_PREFIX; ones = 0;
          end
        end
        lzssd_pkg::PH_LITERAL: if (shift_in(b)) begin
          win[wptr] = acc[7:0]; wptr++; em.push_back(acc[7:0]); phase = lzssd_pkg::PH_FLAG;
        end
        lzssd_pkg::PH_PREFIX: begin
          if (b) begin
            ones++;
            if (ones >= 4) begin
              ones = 4; phase = lzssd_pkg::PH_LENGTH; bits_left = 8; acc = 0;
            end
          end else begin
            phase = lzssd_pkg::PH_LENGTH; bits_left = ones + 1; acc = 0;
          end
        end
        lzssd_pkg::PH_LENGTH: if (shift_in(b)) begin
          if (ones == 4 && acc == lzssd_pkg::END_CODE) hit = 1;
          else begin
            ln = (2 << ones) + acc;
            copy_len = ln > lzssd_pkg::MAX_COPY ? lzssd_pkg::MAX_COPY : ln;
            phase = lzssd_pkg::PH_OFFSET; bits_left = OW; acc = 0;
          end
        end
        lzssd_pkg::PH_OFFSET: if (shift_in(b)) begin
          off = acc[OW-1:0];
          stage.delete();
          for (int k = 0; k < copy_len; k++) stage.push_back(win[off + OW'(k)]);
          for (int k = 0; k < copy_len; k++) begin
            win[wptr + OW'(k)] = stage[k];
            em.push_back(stage[k]);
          end
          wptr += OW'(copy_len);
          phase = lzssd_pkg::PH_FLAG;
        end
        default: phase = lzssd_pkg::PH_FLAG;
      endcase
    end
    for (int i = 0; i < em.size(); i += lzssd_pkg::OUT_LANES) begin
      n = em.size() - i;
      if (n > lzssd_pkg::OUT_LANES) n = lzssd_pkg::OUT_LANES;
      w = '0;
      for (int k = 0; k < n; k++) w.bytes[8*k +: 8] = em[i+k];
      w.count = 4'(n);
      w.last = (i + lzssd_pkg::OUT_LANES >= em.size()) && !hit;
      expected_words.push_back(w);
    end
    if (hit) begin
      ended = 1;
      w = '0; w.last = 1; w.ended = 1;
      expected_words.push_back(w);
    end
  endfunction

  // driver: predicts the words of each byte as it is accepted
  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) decode_byte(compressed_byte_i);
    if (!(in_valid_i && in_stall_o)) begin
      if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle) begin
        in_valid_i <= 1'b1;
        compressed_byte_i <= pending_bytes.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver stall, with a long hold-off when requested
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    dec_word_t w;
    cycles <= cycles + 1;
    if (out_valid_o && !out_stall_i) begin
      if (expected_words.size() == 0) report("unexpected word", out_bytes_o, 0);
      else begin
        w = expected_words.pop_front();
        if (out_bytes_o !== w.bytes) report("out_bytes", out_bytes_o, w.bytes);
        if (byte_count_o !== w.count) report("byte_count", byte_count_o, w.count);
        if (last_of_run_o !== w.last) report("last_of_run", last_of_run_o, w.last);
        if (end_seen_o !== w.ended) report("end_seen", end_seen_o, w.ended);
      end
    end
    if (cycles > 3000000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // bit stream builder
  logic bitbuf[$];

  function automatic void put_bits(input int unsigned v, input int n);
    for (int i = n - 1; i >= 0; i--) bitbuf.push_back(v[i]);
  endfunction

  function automatic void put_literal(input logic [7:0] c);
    put_bits(lit_flag, 1); put_bits(c, 8);
  endfunction

  function automatic void put_copy(input int unsigned len, input int unsigned off);
    put_bits(!lit_flag, 1);
    if (len < 4) begin put_bits(0, 1); put_bits(len - 2, 1); end
    else if (len < 8) begin put_bits(2'b10, 2); put_bits(len - 4, 2); end
    else if (len < 16) begin put_bits(3'b110, 3); put_bits(len - 8, 3); end
    else if (len < 32) begin put_bits(4'b1110, 4); put_bits(len - 16, 4); end
    else begin put_bits(4'b1111, 4); put_bits(len > 271 ? len : len - 32, 8); end
    put_bits(off, OW);
  endfunction

  function automatic void put_end();
    put_bits(!lit_flag, 1); put_bits(4'b1111, 4); put_bits(lzssd_pkg::END_CODE, 8);
  endfunction

  // packs the built bits to bytes, padding the tail randomly
  function automatic void flush_bits();
    logic [7:0] v;
    while (bitbuf.size() % 8 != 0) bitbuf.push_back($urandom_range(1));
    while (bitbuf.size() > 0) begin
      for (int i = 7; i >= 0; i--) v[i] = bitbuf.pop_front();
      pending_bytes.push_back(v);
    end
  endfunction

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= data; penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic drain();
    while (pending_bytes.size() > 0 || in_valid_i || expected_words.size() > 0)
      @(posedge clk_i);
    repeat (1200) @(posedge clk_i);
  endtask

  // changes the literal flag, only with the decoder idle
  task automatic set_flag(input bit f);
    apb_write({lzssd_pkg::REG_LITERAL_FLAG, 2'b00}, {31'd0, f});
    lit_flag = f;
  endtask

  function automatic void random_tokens(input int nbytes);
    int target;
    target = pending_bytes.size() + nbytes;
    while (pending_bytes.size() < target) begin
      case ($urandom_range(9))
        0, 1, 2, 3: put_literal($urandom_range(255));
        4, 5, 6: put_copy($urandom_range(2, 15), $urandom_range(WD - 1));
        7: put_copy($urandom_range(16, 40), $urandom_range(WD - 1));
        8: put_copy($urandom_range(2, 271), $urandom_range(WD - 1));
        default: pending_bytes.push_back($urandom_range(255));
      endcase
      if (bitbuf.size() >= 8 && $urandom_range(3) == 0) begin
        logic [7:0] v;
        for (int i = 7; i >= 0; i--) v[i] = bitbuf.pop_front();
        pending_bytes.push_back(v);
      end
    end
  endfunction

  initial begin
    decoder_reset();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: literal extremes, every length class, wraps, saturating long length
    put_literal(8'h00); put_literal(8'hFF); put_literal(8'hA5);
    put_copy(2, 0); put_copy(3, WD - 1); put_copy(4, 1); put_copy(7, 2);
    put_copy(8, 0); put_copy(15, 1000); put_copy(16, 5); put_copy(31, 3);
    put_copy(32, 0); put_copy(271, 1);
    put_bits(!lit_flag, 1); put_bits(4'b1111, 4); put_bits(8'hF3, 8); put_bits(7, OW);
    flush_bits();
    pending_bytes.push_back(8'h00);
    drain();

    // long receiver hold-off while the sender keeps offering
    send_idle = 0;
    random_tokens(20);
    hold_cycles = 3000;
    drain();
    send_idle = 33; recv_idle = 66;
    random_tokens(130);
    drain();

    set_flag(1'b1);
    send_idle = 66; recv_idle = 33;
    random_tokens(130);
    drain();

    set_flag(1'b0);
    send_idle = 0; recv_idle = 0;
    random_tokens(100);
    put_end();
    flush_bits();
    // ignored after the end
    for (int i = 0; i < 5; i++) pending_bytes.push_back($urandom_range(255));
    drain();

    if (errors == 0 && expected_words.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
